// ===== rtl/hdbn_pkg.sv =====
// Package for the HDBn line encoder: sizes, symbol and register codes,
// the command record passed from front to back, and the order clamp.
// No dependencies.
package hdbn_pkg;

    localparam int MAX_ORDER = 8;
    localparam int ORDER_W   = 4;
    localparam int FILL_W    = $clog2(MAX_ORDER + 1);
    localparam int IDX_W     = $clog2(MAX_ORDER);
    localparam int ZRUN_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = ORDER_W;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        SYM_ZERO = 2'b00,
        SYM_POS  = 2'b01,
        SYM_NEG  = 2'b10
    } t_sym;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER      = 2'd0,
        CFG_START_POL  = 2'd1,
        CFG_START_VIOL = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [ORDER_W-1:0] order;
        logic               start_pol;
        logic               start_viol;
    } t_cfg;

    // One classified bit: its symbol, whether the oldest held symbol
    // becomes a balancing pulse of the same polarity, and the message end.
    typedef struct packed {
        t_sym               sym;
        logic               bal;
        logic               eom;
        logic [ORDER_W-1:0] order;
    } t_cmd;

    function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORDER_W-1:0] v);
        logic [ORDER_W-1:0] r;
        if (v < ORDER_W'(2)) begin
            r = ORDER_W'(2);
        end else if (v > ORDER_W'(MAX_ORDER)) begin
            r = ORDER_W'(MAX_ORDER);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/hdbn_bit_if.sv =====
// Input channel interface: one message bit per item.
// Depends on nothing.
interface hdbn_bit_if;
    logic valid;
    logic ready;
    logic data_bit;
    logic end_of_message;

    modport source (output valid, output data_bit, output end_of_message, input ready);
    modport sink   (input valid, input data_bit, input end_of_message, output ready);
endinterface

// ===== rtl/hdbn_sym_if.sv =====
// Output channel interface: one line symbol per item.
// Depends on nothing.
interface hdbn_sym_if;
    logic valid;
    logic ready;
    logic pulse_pos;
    logic pulse_neg;
    logic last_symbol;

    modport source (output valid, output pulse_pos, output pulse_neg, output last_symbol,
                    input ready);
    modport sink   (input valid, input pulse_pos, input pulse_neg, input last_symbol,
                    output ready);
endinterface

// ===== rtl/hdbn_line_encoder.sv =====
// HDBn line encoder top level: configuration registers, front end, queue, back end.
// Commands are registered in the queue, symbols in the back end's output register.
// Throughput: one bit per cycle unless the output stalls; after the final bit
// the back end drains the held symbols (up to the order) before it pops more.
// Reset (synchronous, active low) empties queue and line; defaults: order 3,
// start polarity positive, first violation negative. Uses front, queue, back.
module hdbn_line_encoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    hdbn_bit_if.sink                           i_bits,
    hdbn_sym_if.source                         o_syms,
    input  logic                               i_cfg_we,
    input  logic [hdbn_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [hdbn_pkg::CFG_W-1:0]         i_cfg_data
);

    // Configuration registers; the front end samples them only at message start,
    // so a write never disturbs a message in flight.
    hdbn_pkg::t_cfg   r_cfg;

    // Front-to-queue and queue-to-back command paths.
    hdbn_pkg::t_cmd   fe_cmd;
    logic             fe_cmd_valid;
    logic             q_ready;
    logic             q_valid;
    hdbn_pkg::t_cmd   q_cmd;
    logic             be_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.order      <= hdbn_pkg::ORDER_W'(3);
            r_cfg.start_pol  <= 1'b0;
            r_cfg.start_viol <= 1'b1;
        end else if (i_cfg_we) begin
            // Drop writes to indexes past the register list.
            unique case (i_cfg_index)
                hdbn_pkg::CFG_ORDER:      r_cfg.order      <= i_cfg_data;
                hdbn_pkg::CFG_START_POL:  r_cfg.start_pol  <= i_cfg_data[0];
                hdbn_pkg::CFG_START_VIOL: r_cfg.start_viol <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Classify each bit: pulse, zero, or violation with optional balancing pulse.
    hdbn_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (i_bits.valid),
        .o_ready          (i_bits.ready),
        .i_data_bit       (i_bits.data_bit),
        .i_end_of_message (i_bits.end_of_message),
        .o_cmd_valid      (fe_cmd_valid),
        .i_cmd_ready      (q_ready),
        .o_cmd            (fe_cmd)
    );

    // Hold commands: front takes bits, until full, while back flushes or stalls.
    hdbn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_cmd_valid),
        .i_cmd   (fe_cmd),
        .o_ready (q_ready),
        .i_pop   (be_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Delay line, registered output; at most one symbol per cycle, sink permitting.
    hdbn_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_cmd_pop     (be_pop),
        .o_valid       (o_syms.valid),
        .i_ready       (o_syms.ready),
        .o_pulse_pos   (o_syms.pulse_pos),
        .o_pulse_neg   (o_syms.pulse_neg),
        .o_last_symbol (o_syms.last_symbol)
    );

endmodule

// ===== rtl/hdbn_front.sv =====
// Front end: tracks pulse and violation polarity and the zero run,
// classifies each bit into a command. Depends on hdbn_pkg.
module hdbn_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hdbn_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_data_bit,
    input  logic                i_end_of_message,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output hdbn_pkg::t_cmd      o_cmd
);

    logic                                 r_active;
    logic                                 r_prev;
    logic                                 r_viol;
    logic [hdbn_pkg::ZRUN_W-1:0]          r_zrun;
    logic [hdbn_pkg::ORDER_W-1:0]         r_order;

    logic                                 n_prev;
    logic                                 n_viol;
    logic [hdbn_pkg::ZRUN_W-1:0]          n_zrun;
    logic                                 cur_prev;
    logic                                 cur_viol;
    logic [hdbn_pkg::ZRUN_W-1:0]          cur_zrun;
    logic [hdbn_pkg::ORDER_W-1:0]         cur_order;
    logic                                 accept;

    assign o_ready     = i_cmd_ready;
    assign o_cmd_valid = i_valid;
    assign accept      = i_valid && i_cmd_ready;

    always_comb begin
        // A bit taken while idle starts a message from the registers.
        cur_prev  = r_active ? r_prev  : i_cfg.start_pol;
        cur_viol  = r_active ? r_viol  : i_cfg.start_viol;
        cur_zrun  = r_active ? r_zrun  : '0;
        cur_order = r_active ? r_order : hdbn_pkg::clamp_order(i_cfg.order);

        n_prev      = cur_prev;
        n_viol      = cur_viol;
        o_cmd.bal   = 1'b0;
        o_cmd.eom   = i_end_of_message;
        o_cmd.order = cur_order;

        if (i_data_bit) begin
            o_cmd.sym = cur_prev ? hdbn_pkg::SYM_POS : hdbn_pkg::SYM_NEG;
            n_prev    = ~cur_prev;
            n_zrun    = '0;
        end else begin
            o_cmd.sym = hdbn_pkg::SYM_ZERO;
            n_zrun    = (cur_zrun == '1) ? cur_zrun : cur_zrun + 1'b1;
            if (n_zrun > hdbn_pkg::ZRUN_W'(cur_order)) begin
                // Substitute: violation here, balancing pulse on the run's first zero
                // when the last pulse does not already carry the violation polarity.
                o_cmd.bal = (cur_prev != cur_viol);
                o_cmd.sym = cur_viol ? hdbn_pkg::SYM_NEG : hdbn_pkg::SYM_POS;
                n_prev    = cur_viol;
                n_viol    = ~cur_viol;
                n_zrun    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (accept) begin
            r_active <= !i_end_of_message;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev  <= n_prev;
            r_viol  <= n_viol;
            r_zrun  <= n_zrun;
            r_order <= cur_order;
        end
    end

endmodule

// ===== rtl/hdbn_queue.sv =====
// Short command queue between front and back.
// Depends on hdbn_pkg.
module hdbn_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hdbn_pkg::t_cmd  i_cmd,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output hdbn_pkg::t_cmd  o_cmd
);

    hdbn_pkg::t_cmd                  r_mem [hdbn_pkg::Q_DEPTH];
    logic [hdbn_pkg::Q_PTR_W-1:0]    r_wptr;
    logic [hdbn_pkg::Q_PTR_W-1:0]    r_rptr;
    logic [hdbn_pkg::Q_CNT_W-1:0]    r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_ready = (r_count != hdbn_pkg::Q_CNT_W'(hdbn_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/hdbn_back.sv =====
// Back end: symbol delay line, release of the oldest symbol and the
// end-of-message flush, into a registered output. Depends on hdbn_pkg.
module hdbn_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  hdbn_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_pulse_pos,
    output logic            o_pulse_neg,
    output logic            o_last_symbol
);

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } t_state;

    t_state                          r_state;
    hdbn_pkg::t_sym                  r_line [hdbn_pkg::MAX_ORDER];
    logic [hdbn_pkg::FILL_W-1:0]     r_fill;
    logic                            r_valid;
    logic                            r_pos;
    logic                            r_neg;
    logic                            r_last;

    t_state                          n_state;
    hdbn_pkg::t_sym                  n_line [hdbn_pkg::MAX_ORDER];
    logic [hdbn_pkg::FILL_W-1:0]     n_fill;
    logic                            n_valid;
    logic                            n_pos;
    logic                            n_neg;
    logic                            n_last;

    hdbn_pkg::t_sym                  shifted [hdbn_pkg::MAX_ORDER];
    hdbn_pkg::t_sym                  head;
    logic [hdbn_pkg::IDX_W-1:0]      tail;
    logic                            out_free;
    logic                            full;

    assign out_free  = !r_valid || i_ready;
    assign o_cmd_pop = (r_state == ST_RUN) && out_free && i_cmd_valid;
    assign full      = (r_fill >= hdbn_pkg::FILL_W'(i_cmd.order));
    assign head      = i_cmd.bal ? i_cmd.sym : r_line[0];
    assign tail      = hdbn_pkg::IDX_W'(r_fill - 1'b1);

    assign o_valid       = r_valid;
    assign o_pulse_pos   = r_pos;
    assign o_pulse_neg   = r_neg;
    assign o_last_symbol = r_last;

    always_comb begin
        for (int i = 0; i < hdbn_pkg::MAX_ORDER - 1; i++) begin
            shifted[i] = r_line[i + 1];
        end
        shifted[hdbn_pkg::MAX_ORDER - 1] = r_line[hdbn_pkg::MAX_ORDER - 1];
    end

    always_comb begin
        n_state = r_state;
        n_line  = r_line;
        n_fill  = r_fill;
        n_valid = r_valid && !i_ready;
        n_pos   = r_pos;
        n_neg   = r_neg;
        n_last  = r_last;
        unique case (r_state)
            ST_RUN: begin
                if (o_cmd_pop) begin
                    if (full) begin
                        // Release the oldest, advance the line, append at the tail.
                        n_valid       = 1'b1;
                        n_pos         = head[0];
                        n_neg         = head[1];
                        n_last        = 1'b0;
                        n_line        = shifted;
                        n_line[tail]  = i_cmd.sym;
                    end else begin
                        n_line[r_fill[hdbn_pkg::IDX_W-1:0]] = i_cmd.sym;
                        n_fill = r_fill + 1'b1;
                    end
                    if (i_cmd.eom) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_valid = 1'b1;
                    n_pos   = r_line[0][0];
                    n_neg   = r_line[0][1];
                    n_last  = (r_fill == hdbn_pkg::FILL_W'(1));
                    n_line  = shifted;
                    n_fill  = r_fill - 1'b1;
                    if (r_fill == hdbn_pkg::FILL_W'(1)) begin
                        n_state = ST_RUN;
                    end
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_fill  <= '0;
            r_valid <= 1'b0;
            r_pos   <= 1'b0;
            r_neg   <= 1'b0;
            r_last  <= 1'b0;
            for (int i = 0; i < hdbn_pkg::MAX_ORDER; i++) begin
                r_line[i] <= hdbn_pkg::SYM_ZERO;
            end
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_valid <= n_valid;
            r_pos   <= n_pos;
            r_neg   <= n_neg;
            r_last  <= n_last;
            for (int i = 0; i < hdbn_pkg::MAX_ORDER; i++) begin
                r_line[i] <= n_line[i];
            end
        end
    end

endmodule

// ===== dv/hdbn_line_encoder_test.sv =====
// Self-checking bench for hdbn_line_encoder: random bit stream in, line symbols checked out.
// Depends on hdbn_pkg, hdbn_bit_if, hdbn_sym_if and the hdbn_line_encoder RTL.
module hdbn_line_encoder_test;
    import hdbn_pkg::*;

    // Drain time after the last expected symbol: covers the queue and output
    // register plus a full delay-line flush, with margin.
    localparam int HOLDOFF     = 2 * MAX_ORDER + 4;
    // Cycles with no item moving on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 2000;
    localparam int RAND_ITEMS  = 290;

    typedef struct packed {
        logic data;
        logic eom;
    } t_msg_bit;

    typedef struct packed {
        logic pos;
        logic neg;
        logic last;
    } t_line_sym;

    // Clock, reset and the block's plain inputs, all known from time zero.
    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               cfg_we    = 1'b0;
    t_cfg_idx           cfg_index = CFG_ORDER;
    logic [CFG_W-1:0]   cfg_data  = '0;

    // Channel-side registers of the driver and the monitor.
    logic bit_vld  = 1'b0;
    logic bit_data = 1'b0;
    logic bit_eom  = 1'b0;
    logic sym_rdy  = 1'b0;

    hdbn_bit_if bits_ch ();
    hdbn_sym_if syms_ch ();

    assign bits_ch.valid          = bit_vld;
    assign bits_ch.data_bit       = bit_data;
    assign bits_ch.end_of_message = bit_eom;
    assign syms_ch.ready          = sym_rdy;

    hdbn_line_encoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bits      (bits_ch),
        .o_syms      (syms_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Encoder model: register copies plus the per-message line state.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cfg_order      = CFG_W'(3);
    logic             cfg_start_pol  = 1'b0;
    logic             cfg_start_viol = 1'b1;

    t_sym        line_q [MAX_ORDER];
    int unsigned line_fill = 0;
    int unsigned zero_run  = 0;
    int unsigned msg_order = 3;
    logic        prev_neg  = 1'b0;
    logic        viol_neg  = 1'b1;

    t_msg_bit  bits_todo [$];   // bits waiting for the driver
    t_line_sym syms_due  [$];   // symbols the encoder owes, oldest first

    int unsigned bits_queued = 0;
    int unsigned bits_taken  = 0;
    int unsigned syms_seen   = 0;
    int unsigned msgs_done   = 0;
    int unsigned violations  = 0;
    int unsigned balancers   = 0;
    int unsigned errors      = 0;
    logic [15:0] orders_used = '0;

    // Reload message state from the registers; clamp order to 2..MAX_ORDER.
    function automatic void restart_msg();
        for (int i = 0; i < MAX_ORDER; i++) line_q[i] = SYM_ZERO;
        line_fill = 0;
        zero_run  = 0;
        prev_neg  = cfg_start_pol;
        viol_neg  = cfg_start_viol;
        if (cfg_order < 2) begin
            msg_order = 2;
        end else if (cfg_order > MAX_ORDER) begin
            msg_order = MAX_ORDER;
        end else begin
            msg_order = cfg_order;
        end
    endfunction

    function automatic void owe_symbol(input t_sym s, input logic last);
        t_line_sym r;
        r.pos  = (s == SYM_POS);
        r.neg  = (s == SYM_NEG);
        r.last = last;
        syms_due.push_back(r);
    endfunction

    // Encode one accepted bit and queue every symbol it releases.
    function automatic void encode_bit(input logic b, input logic eom);
        t_sym        s;
        t_sym        v;
        int unsigned n;
        if (line_fill == 0) begin
            restart_msg();
            orders_used[msg_order] = 1'b1;
        end
        n = msg_order;
        if (b) begin
            // mark: alternate against the previous pulse
            if (prev_neg) begin
                s = SYM_POS;
            end else begin
                s = SYM_NEG;
            end
            prev_neg = ~prev_neg;
            zero_run = 0;
        end else begin
            s = SYM_ZERO;
            if (zero_run < 15) zero_run++;
            if (zero_run > n) begin
                // zero run too long: substitute a violation, and when the
                // previous pulse does not already match it, plant a balancing
                // pulse on the first zero of the run, order places back
                if (viol_neg) begin
                    v = SYM_NEG;
                end else begin
                    v = SYM_POS;
                end
                if (prev_neg != viol_neg && line_fill >= n) begin
                    line_q[line_fill - n] = v;
                    balancers++;
                end
                s        = v;
                prev_neg = viol_neg;
                viol_neg = ~viol_neg;
                zero_run = 0;
                violations++;
            end
        end
        // line full: release the oldest symbol
        if (line_fill >= n) begin
            owe_symbol(line_q[0], 1'b0);
            for (int i = 1; i < line_fill; i++) line_q[i-1] = line_q[i];
            line_fill--;
        end
        if (line_fill < MAX_ORDER) begin
            line_q[line_fill] = s;
            line_fill++;
        end
        // message end: flush everything, mark the final symbol
        if (eom) begin
            for (int i = 0; i < line_fill; i++) owe_symbol(line_q[i], (i + 1) == line_fill);
            restart_msg();
            msgs_done++;
        end
    endfunction

    function automatic void note_mismatch(input string what, input t_line_sym want,
                                          input t_line_sym got);
        errors++;
        if (errors <= 10)
            $display("ERROR symbol %0d: %s want pos=%b neg=%b last=%b got pos=%b neg=%b last=%b",
                     syms_seen, what, want.pos, want.neg, want.last,
                     got.pos, got.neg, got.last);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present queued bits, with a random gap before each one.
    // Burst mode drops the gaps for stretches of back-to-back items.
    // ------------------------------------------------------------------
    int unsigned tx_gap   = 0;
    logic        tx_burst = 1'b0;

    always @(posedge i_clk) begin
        t_msg_bit nxt;
        if (!i_rst_n) begin
            bit_vld <= 1'b0;
            tx_gap = 0;
        end else begin
            if (bit_vld && bits_ch.ready) begin
                encode_bit(bit_data, bit_eom);
                bits_taken++;
                tx_gap = tx_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0) tx_burst = ~tx_burst;
            end
            // hold the current item while it is stalled; otherwise advance
            if (!bit_vld || bits_ch.ready) begin
                if (tx_gap != 0 || bits_todo.size() == 0) begin
                    bit_vld <= 1'b0;
                    if (tx_gap != 0) tx_gap--;
                end else begin
                    nxt = bits_todo.pop_front();
                    bit_vld  <= 1'b1;
                    bit_data <= nxt.data;
                    bit_eom  <= nxt.eom;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: take symbols with random back-pressure, check each one
    // against the oldest owed symbol.
    // ------------------------------------------------------------------
    int unsigned rx_stall = 0;
    logic        rx_burst = 1'b0;

    always @(posedge i_clk) begin
        t_line_sym got;
        t_line_sym want;
        if (!i_rst_n) begin
            sym_rdy <= 1'b0;
            rx_stall = 0;
        end else begin
            if (syms_ch.valid && sym_rdy) begin
                got.pos  = syms_ch.pulse_pos;
                got.neg  = syms_ch.pulse_neg;
                got.last = syms_ch.last_symbol;
                if (syms_due.size() == 0) begin
                    note_mismatch("unexpected symbol,", '0, got);
                end else begin
                    want = syms_due.pop_front();
                    if (got.pos !== want.pos || got.neg !== want.neg
                            || got.last !== want.last)
                        note_mismatch("mismatch,", want, got);
                end
                syms_seen++;
                rx_stall = rx_burst ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
            end else if (rx_stall != 0) begin
                rx_stall--;
            end
            sym_rdy <= (rx_stall == 0);
        end
    end

    // Watchdog: abandon the run if neither channel moves for too long.
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((bit_vld && bits_ch.ready) || (syms_ch.valid && sym_rdy)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no traffic for %0d cycles, %0d symbols still owed",
                         STALL_LIMIT, syms_due.size());
                $display("hdbn_line_encoder regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_bit(input logic d, input logic eom);
        t_msg_bit m;
        m.data = d;
        m.eom  = eom;
        bits_todo.push_back(m);
        bits_queued++;
    endtask

    // Wait until every queued bit is taken and every owed symbol has come,
    // then let the back end settle.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (bits_taken != bits_queued || syms_due.size() != 0);
        repeat (HOLDOFF) @(posedge i_clk);
    endtask

    // One register write; only called while the encoder is idle.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ORDER:      cfg_order      = val;
            CFG_START_POL:  cfg_start_pol  = val[0];
            CFG_START_VIOL: cfg_start_viol = val[0];
            default: ;
        endcase
    endtask

    // Write the polarity registers with random filler in the unused bits.
    task automatic write_polarities(input logic pol, input logic viol);
        logic [CFG_W-2:0] junk;
        junk = (CFG_W-1)'($urandom_range(0, (1 << (CFG_W - 1)) - 1));
        write_reg(CFG_START_POL, {junk, pol});
        junk = (CFG_W-1)'($urandom_range(0, (1 << (CFG_W - 1)) - 1));
        write_reg(CFG_START_VIOL, {junk, viol});
    endtask

    initial begin
        int unsigned rand_items;
        int unsigned phase;
        int unsigned phase_items;
        int unsigned len;
        logic        zero_heavy;
        logic        pause_done;
        logic [CFG_W-1:0] ord;
        logic [CFG_W-1:0] order_picks [6];

        order_picks = '{CFG_W'(2), CFG_W'(MAX_ORDER), CFG_W'(0), CFG_W'(15),
                        CFG_W'(1), CFG_W'(MAX_ORDER + 1)};
        rand_items  = 0;
        phase       = 0;
        pause_done  = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults (order 3): a mark, then a zero run whose violation
        // already matches the last pulse, then one that needs balancing.
        push_bit(1'b1, 1'b0);
        repeat (4) push_bit(1'b0, 1'b0);
        repeat (4) push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b1);
        // one-bit message: flush of a nearly empty line
        push_bit(1'b0, 1'b1);
        wait_idle();

        // Order below range acts as 2; flip both start polarities so the
        // very first violation needs a balancing pulse.
        write_reg(CFG_ORDER, CFG_W'(0));
        write_polarities(1'b1, 1'b0);
        repeat (6) push_bit(1'b0, 1'b0);
        push_bit(1'b1, 1'b1);
        wait_idle();

        // Order above range acts as MAX_ORDER; the final zero both violates
        // and flushes a full line, giving the most symbols from one bit.
        write_reg(CFG_ORDER, CFG_W'(15));
        repeat (MAX_ORDER) push_bit(1'b0, 1'b0);
        push_bit(1'b0, 1'b1);

        // Random phases: new registers each phase, then whole messages.
        while (rand_items < RAND_ITEMS) begin
            wait_idle();
            ord = (phase < 6) ? order_picks[phase] : CFG_W'($urandom_range(0, 15));
            write_reg(CFG_ORDER, ord);
            if (phase < 4) begin
                write_polarities(phase[0], phase[1]);
            end else begin
                write_polarities(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            phase_items = 0;
            while (phase_items < 50 && rand_items < RAND_ITEMS) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 16);
                if (phase >= 2 && !pause_done) len = 12;
                zero_heavy = 1'($urandom_range(0, 1));
                for (int k = 0; k < len; k++) begin
                    // once, stop mid-message and let the encoder run dry
                    if (phase >= 2 && !pause_done && k == len / 2) begin
                        wait_idle();
                        pause_done = 1'b1;
                    end
                    push_bit(zero_heavy ? ($urandom_range(0, 4) == 0)
                                        : 1'($urandom_range(0, 1)),
                             k == len - 1);
                end
                phase_items += len;
                rand_items  += len;
            end
            phase++;
        end

        wait_idle();
        $display("covered %0d bits in %0d messages over %0d register settings, %0d orders",
                 bits_taken, msgs_done, phase + 3, $countones(orders_used));
        $display("checked %0d symbols: %0d violations, %0d balancing pulses, %0d errors",
                 syms_seen, violations, balancers, errors);
        if (errors == 0) begin
            $display("hdbn_line_encoder regression: pass");
        end else begin
            $display("hdbn_line_encoder regression: fail");
        end
        $finish;
    end

endmodule
